// File: sv/sha1c_pkg.sv
// sha1c_pkg: shared types and constants of the SHA-1 hash engine.
// Used by sha1c_round_unit and sha1_hash_engine_core; depends on nothing.

package sha1c_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FIN,
      ST_EMIT_RD,
      ST_EMIT_CAP
   } sha1c_state_type;

   // Controls from the sequencer to the round datapath
   typedef struct packed {
      logic       w_shift;   // shift a block word into the schedule
      logic       v_shift;   // shift a chaining word into a..e
      logic       round_en;  // run one compression round
      logic       v_rotate;  // move b..e down to a for the final add
      logic [6:0] rnd;       // round number 0..79
   } sha1c_ctl_type;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0]  PAD_MARK  = 8'h80;
   localparam int          NUM_CHAIN = 5;

   // Initial chaining values h0..h4
   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] val;
      case (idx)
         3'd0:    val = 32'h67452301;
         3'd1:    val = 32'hEFCDAB89;
         3'd2:    val = 32'h98BADCFE;
         3'd3:    val = 32'h10325476;
         3'd4:    val = 32'hC3D2E1F0;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage

// File: sv/sha1c_round_unit.sv
// sha1c_round_unit: message schedule shift line and a..e working registers,
// one SHA-1 round per cycle while ctl.round_en is set. Depends on sha1c_pkg.

module sha1c_round_unit (
   input  logic                   clock,
   input  sha1c_pkg::sha1c_ctl_type ctl,
   input  logic [31:0]            blk_q,    // block word read from buffer
   input  logic [31:0]            chain_q,  // chaining word read from store
   output logic [31:0]            var_a     // working word a, for the final add
);

   logic [31:0] w_ff [0:15];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;

   logic [31:0] w_mix;
   logic [31:0] w_new;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;

   // schedule expansion: W[t+16] from the taps W[t+13], W[t+8], W[t+2], W[t]
   assign w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign w_new = {w_mix[30:0], w_mix[31]};

   // round function and constant by round group
   always_comb begin
      if (ctl.rnd < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1c_pkg::K0;
      end else if (ctl.rnd < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1c_pkg::K1;
      end else if (ctl.rnd < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1c_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1c_pkg::K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];

   // schedule line
   always_ff @(posedge clock) begin
      if (ctl.w_shift) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= blk_q;
      end else if (ctl.round_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_new;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctl.v_shift) begin
         a_ff <= b_ff;
         b_ff <= c_ff;
         c_ff <= d_ff;
         d_ff <= e_ff;
         e_ff <= chain_q;
      end else if (ctl.round_en) begin
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end else if (ctl.v_rotate) begin
         a_ff <= b_ff;
         b_ff <= c_ff;
         c_ff <= d_ff;
         d_ff <= e_ff;
         e_ff <= '0;
      end
   end

   assign var_a = a_ff;

endmodule

// File: sv/sha1_hash_engine_core.sv
// sha1_hash_engine_core: SHA-1 digest of a byte stream, block buffer and
// chaining words held in synchronous memories. Depends on sha1c_pkg, sha1c_round_unit.
//
//   channel | direction | tdata            | tuser          | tlast
//   req_    | in        | [7:0] msg_byte   | byte_valid     | end_of_message
//   rsp_    | out       | [31:0] digest    | [2:0] word_idx | last_word
//
// Bytes are taken while the core is idle; the 64th byte of a block starts a
// compression (block buffer reads, 80 rounds, then a read-modify-write of each
// chaining word) during which no byte is taken. An end item adds padding writes
// and one or two compressions, then the digest words are read out while rsp_ is ready.
// Reset is synchronous; the chaining store reads as the initial values until
// written, so no clearing pass is needed. rsp_ backpressure holds the digest
// sequence; the last word waits in the output register while new bytes go in.

module sha1_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   sha1c_pkg::sha1c_state_type state_ff, state_in;

   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        end_ff, end_in;
   logic        marked_ff, marked_in;
   logic        extra_ff, extra_in;
   logic [3:0]  wptr_ff, wptr_in;
   logic [4:0]  ld_cnt_ff, ld_cnt_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  fin_cnt_ff, fin_cnt_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   logic [4:0]  chain_vld_ff, chain_vld_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_idx_ff, rsp_idx_in;
   logic        rsp_last_ff, rsp_last_in;

   // block buffer memory
   logic [31:0] blk_mem [0:15];
   logic        blk_we;
   logic [3:0]  blk_wa;
   logic [31:0] blk_wd;
   logic [3:0]  blk_ra;
   logic [31:0] blk_q_ff;

   // chaining word memory
   logic [31:0] ch_mem [0:4];
   logic        ch_we;
   logic [2:0]  ch_wa;
   logic [31:0] ch_wd;
   logic [2:0]  ch_ra;
   logic [31:0] ch_mem_q_ff;
   logic [2:0]  ch_ra_ff;
   logic        ch_rvld_ff;
   logic [31:0] ch_q;

   sha1c_pkg::sha1c_ctl_type ctl;
   logic [31:0] var_a;
   logic [31:0] byte_word;
   logic [31:0] mark_word;
   logic [31:0] pad_word;

   sha1c_round_unit u_round (
      .clock   (clock),
      .ctl     (ctl),
      .blk_q   (blk_q_ff),
      .chain_q (ch_q),
      .var_a   (var_a)
   );

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (blk_we) blk_mem[blk_wa] <= blk_wd;
      blk_q_ff <= blk_mem[blk_ra];
   end

   always_ff @(posedge clock) begin
      if (ch_we) ch_mem[ch_wa] <= ch_wd;
      ch_mem_q_ff <= ch_mem[ch_ra];
      ch_ra_ff    <= ch_ra;
      ch_rvld_ff  <= chain_vld_ff[ch_ra];
   end

   // unwritten chaining entries read as the initial values
   assign ch_q = ch_rvld_ff ? ch_mem_q_ff : sha1c_pkg::init_word(ch_ra_ff);

   // byte merged into the word being gathered, big-endian
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    byte_word = {req_tdata, 24'h0};
         2'd1:    byte_word = acc_ff | {8'h0, req_tdata, 16'h0};
         2'd2:    byte_word = acc_ff | {16'h0, req_tdata, 8'h0};
         2'd3:    byte_word = acc_ff | {24'h0, req_tdata};
         default: byte_word = acc_ff;
      endcase
   end

   // padding marker merged after the last byte
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mark_word = {sha1c_pkg::PAD_MARK, 24'h0};
         2'd1:    mark_word = acc_ff | {8'h0, sha1c_pkg::PAD_MARK, 16'h0};
         2'd2:    mark_word = acc_ff | {16'h0, sha1c_pkg::PAD_MARK, 8'h0};
         2'd3:    mark_word = acc_ff | {24'h0, sha1c_pkg::PAD_MARK};
         default: mark_word = acc_ff;
      endcase
   end

   // zero fill, with the bit length in the last two words of the final block
   always_comb begin
      if (!extra_ff && wptr_ff == 4'd14)      pad_word = bitlen_ff[63:32];
      else if (!extra_ff && wptr_ff == 4'd15) pad_word = bitlen_ff[31:0];
      else                                    pad_word = 32'h0;
   end

   // sequencer: next state and controls
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      bitlen_in    = bitlen_ff;
      end_in       = end_ff;
      marked_in    = marked_ff;
      extra_in     = extra_ff;
      wptr_in      = wptr_ff;
      ld_cnt_in    = ld_cnt_ff;
      rnd_in       = rnd_ff;
      fin_cnt_in   = fin_cnt_ff;
      emit_idx_in  = emit_idx_ff;
      chain_vld_in = chain_vld_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      blk_we       = 1'b0;
      blk_wa       = cnt_ff[5:2];
      blk_wd       = byte_word;
      blk_ra       = ld_cnt_ff[3:0];
      ch_we        = 1'b0;
      ch_wa        = fin_cnt_ff - 3'd1;
      ch_wd        = ch_q + var_a;
      ch_ra        = 3'd0;
      ctl          = '0;
      ctl.rnd      = rnd_ff;

      case (state_ff)
         sha1c_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  acc_in    = byte_word;
                  cnt_in    = cnt_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
                  blk_we    = (cnt_ff[1:0] == 2'd3);
               end
               end_in = req_tlast;
               if (req_tuser && cnt_ff == 6'd63) begin
                  ld_cnt_in = '0;
                  state_in  = sha1c_pkg::ST_LOAD;
               end else if (req_tlast) begin
                  state_in = sha1c_pkg::ST_MARK;
               end
            end
         end

         sha1c_pkg::ST_MARK: begin
            blk_we    = 1'b1;
            blk_wd    = mark_word;
            marked_in = 1'b1;
            extra_in  = (cnt_ff[5:2] >= 4'd14);
            if (cnt_ff[5:2] == 4'd15) begin
               ld_cnt_in = '0;
               state_in  = sha1c_pkg::ST_LOAD;
            end else begin
               wptr_in  = cnt_ff[5:2] + 4'd1;
               state_in = sha1c_pkg::ST_PAD;
            end
         end

         sha1c_pkg::ST_PAD: begin
            blk_we = 1'b1;
            blk_wa = wptr_ff;
            blk_wd = pad_word;
            if (wptr_ff == 4'd15) begin
               ld_cnt_in = '0;
               state_in  = sha1c_pkg::ST_LOAD;
            end else begin
               wptr_in = wptr_ff + 4'd1;
            end
         end

         sha1c_pkg::ST_LOAD: begin
            ch_ra       = (ld_cnt_ff < 5'd5) ? ld_cnt_ff[2:0] : 3'd0;
            ctl.w_shift = (ld_cnt_ff != 5'd0);
            ctl.v_shift = (ld_cnt_ff != 5'd0) && (ld_cnt_ff <= 5'd5);
            if (ld_cnt_ff == 5'd16) begin
               rnd_in   = '0;
               state_in = sha1c_pkg::ST_ROUND;
            end else begin
               ld_cnt_in = ld_cnt_ff + 5'd1;
            end
         end

         sha1c_pkg::ST_ROUND: begin
            ctl.round_en = 1'b1;
            if (rnd_ff == 7'd79) begin
               fin_cnt_in = '0;
               state_in   = sha1c_pkg::ST_FIN;
            end else begin
               rnd_in = rnd_ff + 7'd1;
            end
         end

         sha1c_pkg::ST_FIN: begin
            // read word j while word j-1 gets its sum written back
            ch_ra = (fin_cnt_ff < 3'd5) ? fin_cnt_ff : 3'd0;
            if (fin_cnt_ff != 3'd0) begin
               ch_we        = 1'b1;
               ctl.v_rotate = 1'b1;
               chain_vld_in = chain_vld_ff | (5'd1 << ch_wa);
            end
            if (fin_cnt_ff == 3'd5) begin
               if (!end_ff) begin
                  state_in = sha1c_pkg::ST_IDLE;
               end else if (!marked_ff) begin
                  state_in = sha1c_pkg::ST_MARK;
               end else if (extra_ff) begin
                  extra_in = 1'b0;
                  wptr_in  = '0;
                  state_in = sha1c_pkg::ST_PAD;
               end else begin
                  emit_idx_in = '0;
                  state_in    = sha1c_pkg::ST_EMIT_RD;
               end
            end else begin
               fin_cnt_in = fin_cnt_ff + 3'd1;
            end
         end

         sha1c_pkg::ST_EMIT_RD: begin
            ch_ra    = emit_idx_ff;
            state_in = sha1c_pkg::ST_EMIT_CAP;
         end

         sha1c_pkg::ST_EMIT_CAP: begin
            ch_ra = emit_idx_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ch_q;
               rsp_idx_in   = emit_idx_ff;
               rsp_last_in  = (emit_idx_ff == 3'(sha1c_pkg::NUM_CHAIN - 1));
               if (emit_idx_ff == 3'(sha1c_pkg::NUM_CHAIN - 1)) begin
                  // start over for the next message
                  cnt_in       = '0;
                  bitlen_in    = '0;
                  end_in       = 1'b0;
                  marked_in    = 1'b0;
                  extra_in     = 1'b0;
                  chain_vld_in = '0;
                  state_in     = sha1c_pkg::ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 3'd1;
                  state_in    = sha1c_pkg::ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = sha1c_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1c_pkg::ST_IDLE;
         cnt_ff       <= '0;
         bitlen_ff    <= '0;
         end_ff       <= 1'b0;
         marked_ff    <= 1'b0;
         extra_ff     <= 1'b0;
         wptr_ff      <= '0;
         ld_cnt_ff    <= '0;
         rnd_ff       <= '0;
         fin_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         chain_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bitlen_ff    <= bitlen_in;
         end_ff       <= end_in;
         marked_ff    <= marked_in;
         extra_ff     <= extra_in;
         wptr_ff      <= wptr_in;
         ld_cnt_ff    <= ld_cnt_in;
         rnd_ff       <= rnd_in;
         fin_cnt_ff   <= fin_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         chain_vld_ff <= chain_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_round_to_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1c_pkg::ST_ROUND && rnd_ff == 7'd79)
         |=> (state_ff == sha1c_pkg::ST_FIN))
      else $error("compression did not leave the last round for the final add");

   a_chain_wr_in_fin: assert property (@(posedge clock) disable iff (reset)
      ch_we |-> (state_ff == sha1c_pkg::ST_FIN && fin_cnt_ff != 3'd0))
      else $error("chaining store written outside the final add");

   a_blk_wr_not_busy: assert property (@(posedge clock) disable iff (reset)
      blk_we |-> !(state_ff == sha1c_pkg::ST_LOAD || state_ff == sha1c_pkg::ST_ROUND))
      else $error("block buffer written during compression");

   a_emit_after_pad: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1c_pkg::ST_EMIT_RD) |-> (marked_ff && !extra_ff && end_ff))
      else $error("digest read before padding finished");

   a_last_word_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready) && rsp_last_in)
         |=> (rsp_idx_ff == 3'(sha1c_pkg::NUM_CHAIN - 1) && chain_vld_ff == 5'd0))
      else $error("last digest word loaded without restarting the chain");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for sha1_hash_engine_core.
// Streams byte messages into req_, predicts each SHA-1 digest and checks rsp_.
// Depends on sha1_hash_engine_core and sha1c_pkg (compiled with the RTL).

module tb_top;

   // SHA-1 initial chaining values and round constants
   localparam logic [31:0] IV_H0 = 32'h67452301;
   localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_H2 = 32'h98BADCFE;
   localparam logic [31:0] IV_H3 = 32'h10325476;
   localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;
   localparam logic [31:0] K_R0  = 32'h5A827999;
   localparam logic [31:0] K_R1  = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2  = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3  = 32'hCA62C1D6;
   localparam logic [7:0]  END_MARK     = 8'h80;
   localparam int          DIGEST_WORDS = 5;
   localparam int          LEN_FIELD_AT = 56;   // byte offset of the length field
   localparam int          RANDOM_ITEMS = 300;
   localparam int          HOLD_CYCLES  = 600;
   localparam int          MAX_REPORTS  = 10;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] msg_byte
   logic        req_tuser  = 1'b0;   // [0] byte_valid
   logic        req_tlast  = 1'b0;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_index
   logic        rsp_tlast;           // last_word

   // predictor state
   logic [31:0] hash_chain [DIGEST_WORDS];
   logic [31:0] msg_block [16];
   logic [5:0]  fill_count;
   logic [63:0] bit_len;

   digest_word_type digest_q [$];
   int mismatch_count   = 0;
   int item_count       = 0;
   int digests_expected = 0;

   // sender and receiver pacing
   int burst_left  = 0;
   bit sender_gaps = 1'b1;
   int hold_len    = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int rx_left   = 0;
   int rx_phase  = 0;
   int rx_period = 2;
   int rx_duty   = 1;
   int boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sha1_hash_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void clear_hash_state();
      hash_chain[0] = IV_H0;
      hash_chain[1] = IV_H1;
      hash_chain[2] = IV_H2;
      hash_chain[3] = IV_H3;
      hash_chain[4] = IV_H4;
      foreach (msg_block[j]) msg_block[j] = 32'h0;
      fill_count = 6'd0;
      bit_len    = 64'd0;
   endfunction

   // 80 rounds over the block buffer, added into the chaining words
   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++) w[i] = msg_block[i];
      for (i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_R0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_R1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_R2;
         end else begin
            f = b ^ c ^ d;
            k = K_R3;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
      foreach (msg_block[j]) msg_block[j] = 32'h0;
      fill_count = 6'd0;
   endfunction

   // big-endian byte placement; a full block compresses at once
   function automatic void put_block_byte(input logic [7:0] data);
      msg_block[fill_count[5:2]][(3 - fill_count[1:0]) * 8 +: 8] = data;
      fill_count = fill_count + 6'd1;
      if (fill_count == 6'd0) compress_block();
   endfunction

   // one accepted input transfer; an end item queues the five digest words
   function automatic void hash_item(input logic [7:0] data, input logic valid,
                                     input logic last);
      logic [63:0]     msg_len;
      digest_word_type dw;
      int i;
      if (valid) begin
         put_block_byte(data);
         bit_len += 64'd8;
      end
      if (last) begin
         msg_len = bit_len;
         put_block_byte(END_MARK);
         while (fill_count != LEN_FIELD_AT) put_block_byte(8'h00);
         msg_block[14] = msg_len[63:32];
         msg_block[15] = msg_len[31:0];
         compress_block();
         for (i = 0; i < DIGEST_WORDS; i++) begin
            dw.word  = hash_chain[i];
            dw.index = 3'(i);
            dw.last  = (i == DIGEST_WORDS - 1);
            digest_q.insert(digest_q.size(), dw);
         end
         digests_expected++;
         clear_hash_state();
      end
   endfunction

   // ---------------------------------------------------------------- checker

   function automatic void report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endfunction

   always @(posedge clock) begin : check_digest
      digest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h index %0d last %b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = digest_q.pop_front();
            if (rsp_tdata !== want.word || rsp_tuser !== want.index
                || rsp_tlast !== want.last) begin
               report_mismatch($sformatf(
                  "expected word %h index %0d last %b, got %h index %0d last %b",
                  want.word, want.index, want.last, rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // long hold-off on request, otherwise a stall pattern that changes now and then
   initial begin
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            hold_len--;
         end else begin
            if (rx_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 2));
               rx_left   = $urandom_range(20, 150);
               rx_period = $urandom_range(2, 9);
               rx_duty   = $urandom_range(1, rx_period - 1);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
               RX_ALWAYS: begin
                  rsp_tready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_tready <= ((rx_phase % rx_period) < rx_duty);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // offer one item, in bursts with random gaps; predict on the transfer
   task automatic send_item(input logic [7:0] data, input logic valid, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= valid;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      hash_item(data, valid, last);
      if (valid || last) item_count++;
   endtask

   // random content; the end rides on the last byte or comes as a bare end item
   task automatic send_message(input int len, input bit end_alone);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone);
      end
      if (end_alone || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // empty message, twice in a row, data ignored
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      // "abc", end on the last byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // single byte extremes
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      // idle item inside a message, then an end without a byte
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
   endtask

   // receiver holds off while short messages keep coming, so the input stalls
   task automatic test_backpressure();
      int m;
      sender_gaps = 1'b0;
      hold_len = HOLD_CYCLES;
      for (m = 0; m < 6; m++) send_message($urandom_range(4, 20), 1'b0);
      sender_gaps = 1'b1;
   endtask

   // mostly short messages and padding-boundary lengths, with idle noise
   task automatic test_random_messages();
      int start, pick, len;
      start = item_count;
      while (item_count - start < RANDOM_ITEMS || digests_expected < 12) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         pick = $urandom_range(0, 9);
         if (pick < 5) len = $urandom_range(0, 8);
         else if (pick < 8) len = boundary_len[$urandom_range(0, 9)];
         else len = $urandom_range(0, 140);
         send_message(len, $urandom_range(0, 3) == 0);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_hash_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_messages();
      @(negedge clock);
      req_tvalid <= 1'b0;
      // drain, then leave room for anything extra to show up
      while (digest_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
